>>> src/multi_stack_in_one_memory_defines.svh
`ifndef MULTI_STACK_IN_ONE_MEMORY_DEFINES_SVH
`define MULTI_STACK_IN_ONE_MEMORY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSIM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/msim_pkg.sv
`default_nettype none

package msim_pkg;

    localparam int MAX_STACKS   = 8;
    localparam int MAX_CAPACITY = 64;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int SID_IN_W = 4;
    localparam int STK_CFG_W = 4;
    localparam int CAP_CFG_W = 7;
    localparam int CFG_W   = (STK_CFG_W > CAP_CFG_W) ? STK_CFG_W : CAP_CFG_W;

    localparam int SID_W   = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int NSTK_W  = $clog2(MAX_STACKS + 1);
    localparam int CNT_W   = $clog2(MAX_CAPACITY + 1);
    localparam int DEPTH   = MAX_STACKS * MAX_CAPACITY;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDEF = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        CFG_STACKS   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> src/msim_ctrl.sv
`default_nettype none

`include "multi_stack_in_one_memory_defines.svh"

module msim_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output msim_pkg::t_dp_cmd      o_cmd
);

    msim_pkg::t_state r_state;
    msim_pkg::t_state n_state;
    logic             in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msim_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msim_pkg::S_IDLE: begin
                if (i_in_valid) n_state = msim_pkg::S_EXEC;
            end
            msim_pkg::S_EXEC: begin
                n_state = msim_pkg::S_OUT;
            end
            msim_pkg::S_OUT: begin
                if (!i_out_stall) n_state = msim_pkg::S_IDLE;
            end
            default: begin
                n_state = msim_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            msim_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            msim_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            msim_pkg::S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    `MSIM_ASSERT_NEXT(a_accept_to_exec, in_accept, r_state == msim_pkg::S_EXEC, "accepted request did not start execution")
    `MSIM_ASSERT_NEXT(a_exec_to_out, o_cmd.exec, o_out_valid, "execution not followed by a result")
    `MSIM_ASSERT_NOW(a_one_in_flight, o_out_valid, o_in_stall, "new request taken while result pending")
    `MSIM_ASSERT_NOW(a_load_only_idle, o_cmd.load, !o_cmd.exec && !o_out_valid, "load outside idle")

endmodule

`default_nettype wire

>>> src/msim_dp.sv
`default_nettype none

module msim_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire msim_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [msim_pkg::NSTK_W-1:0]         i_eff_stacks,
    input  wire logic [msim_pkg::CNT_W-1:0]          i_eff_capacity,
    input  wire logic [msim_pkg::OP_W-1:0]           i_opcode,
    input  wire logic [msim_pkg::SID_IN_W-1:0]       i_stack_id,
    input  wire logic signed [msim_pkg::DATA_W-1:0]  i_push_value,
    output logic [1:0]                               o_status,
    output logic signed [msim_pkg::DATA_W-1:0]       o_top_value,
    output logic                                     o_stack_empty
);

    msim_pkg::t_opcode                   r_op;
    logic [msim_pkg::SID_IN_W-1:0]       r_sid;
    logic [msim_pkg::DATA_W-1:0]         r_val;
    logic [msim_pkg::CNT_W-1:0]          r_cnt [msim_pkg::MAX_STACKS];
    msim_pkg::t_status                   r_status;
    logic [msim_pkg::DATA_W-1:0]         r_top;
    logic                                r_peek_ok;
    logic                                r_empty;
    logic [msim_pkg::DATA_W-1:0]         r_rd_data;
    logic [msim_pkg::DATA_W-1:0]         mem [msim_pkg::DEPTH];

    logic [msim_pkg::SID_W-1:0]          sid_idx;
    logic                                sid_ok;
    logic [msim_pkg::CNT_W-1:0]          cnt;
    logic [msim_pkg::CNT_W-1:0]          n_cnt;
    msim_pkg::t_status                   n_status;
    logic [msim_pkg::DATA_W-1:0]         n_top;
    logic                                n_peek_ok;
    logic                                mem_we;
    logic                                mem_re;
    logic [msim_pkg::CNT_W-1:0]          slot;
    logic [msim_pkg::ADDR_W-1:0]         addr;

    assign sid_idx = msim_pkg::SID_W'(r_sid);
    // eff_stacks never exceeds MAX_STACKS, so this also bounds the index
    assign sid_ok  = 32'(r_sid) < 32'(i_eff_stacks);
    assign cnt     = r_cnt[sid_idx];

    always_comb begin
        n_status  = msim_pkg::ST_OK;
        n_top     = '0;
        n_peek_ok = 1'b0;
        n_cnt     = cnt;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        slot      = cnt;
        if (!sid_ok) begin
            n_status = msim_pkg::ST_UNDEF;
            if (r_op == msim_pkg::OP_PEEK) n_top = '1;
        end else begin
            case (r_op)
                msim_pkg::OP_PUSH: begin
                    if (cnt >= i_eff_capacity) begin
                        n_status = msim_pkg::ST_FULL;
                    end else begin
                        mem_we = 1'b1;
                        n_cnt  = cnt + msim_pkg::CNT_W'(1);
                    end
                end
                msim_pkg::OP_POP: begin
                    if (cnt == '0) n_status = msim_pkg::ST_EMPTY;
                    else           n_cnt    = cnt - msim_pkg::CNT_W'(1);
                end
                msim_pkg::OP_PEEK: begin
                    slot = cnt - msim_pkg::CNT_W'(1);
                    if (cnt == '0) begin
                        n_status = msim_pkg::ST_EMPTY;
                        n_top    = '1;
                    end else begin
                        mem_re    = 1'b1;
                        n_peek_ok = 1'b1;
                    end
                end
                default: begin
                    n_status = msim_pkg::ST_OK;
                end
            endcase
        end
    end

    assign addr = msim_pkg::ADDR_W'(32'(sid_idx) * msim_pkg::MAX_CAPACITY + 32'(slot));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= msim_pkg::t_opcode'(i_opcode);
            r_sid <= i_stack_id;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_top     <= n_top;
            r_peek_ok <= n_peek_ok;
            r_empty   <= sid_ok && (n_cnt == '0);
        end
    end

    // single-port shared store, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) mem[addr] <= r_val;
        if (i_cmd.exec && mem_re) r_rd_data <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msim_pkg::MAX_STACKS; i++) r_cnt[i] <= '0;
        end else if (i_cmd.exec && sid_ok) begin
            r_cnt[sid_idx] <= n_cnt;
        end
    end

    assign o_status      = r_status;
    assign o_top_value   = r_peek_ok ? r_rd_data : r_top;
    assign o_stack_empty = r_empty;

endmodule

`default_nettype wire

>>> src/multi_stack_in_one_memory.sv
`default_nettype none

// Several stacks in one shared single-port memory, each owning a fixed slice
// of MAX_CAPACITY words; a fill count per stack sits in flip-flops and is
// cleared by reset, the entry memory itself is not cleared. Each request is
// one push, pop, peek or empty query and gives exactly one result. A request
// goes through accept, execute with the one memory access, and present
// result, as the single memory port and its registered read demand; the
// next request is taken once the result has been collected, so one request
// is held at a time. Configuration is written through the plain write port,
// by the user only while idle; the block itself does not enforce this.
module multi_stack_in_one_memory (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [msim_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [msim_pkg::OP_W-1:0]           i_opcode,
    input  wire logic [msim_pkg::SID_IN_W-1:0]       i_stack_id,
    input  wire logic signed [msim_pkg::DATA_W-1:0]  i_push_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_status,
    output logic signed [msim_pkg::DATA_W-1:0]       o_top_value,
    output logic                                     o_stack_empty
);

    logic [msim_pkg::STK_CFG_W-1:0] r_stacks_in_use;
    logic [msim_pkg::CAP_CFG_W-1:0] r_stack_capacity;
    logic [msim_pkg::NSTK_W-1:0]    eff_stacks;
    logic [msim_pkg::CNT_W-1:0]     eff_capacity;
    msim_pkg::t_dp_cmd              cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks_in_use  <= msim_pkg::STK_CFG_W'(8);
            r_stack_capacity <= msim_pkg::CAP_CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (msim_pkg::t_cfg_index'(i_cfg_index))
                msim_pkg::CFG_STACKS:   r_stacks_in_use  <= i_cfg_data[msim_pkg::STK_CFG_W-1:0];
                msim_pkg::CFG_CAPACITY: r_stack_capacity <= i_cfg_data[msim_pkg::CAP_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to what the memory holds
    assign eff_stacks = (32'(r_stacks_in_use) > msim_pkg::MAX_STACKS)
                      ? msim_pkg::NSTK_W'(msim_pkg::MAX_STACKS)
                      : msim_pkg::NSTK_W'(r_stacks_in_use);
    assign eff_capacity = (32'(r_stack_capacity) > msim_pkg::MAX_CAPACITY)
                        ? msim_pkg::CNT_W'(msim_pkg::MAX_CAPACITY)
                        : msim_pkg::CNT_W'(r_stack_capacity);

    msim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    msim_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_eff_stacks   (eff_stacks),
        .i_eff_capacity (eff_capacity),
        .i_opcode       (i_opcode),
        .i_stack_id     (i_stack_id),
        .i_push_value   (i_push_value),
        .o_status       (o_status),
        .o_top_value    (o_top_value),
        .o_stack_empty  (o_stack_empty)
    );

endmodule

`default_nettype wire

>>> bench/stack_op_checker.sv
`default_nettype none

// Watches the request and result channels of the stack block, keeps its own
// copy of the stacks and registers, and compares every result in order.
module stack_op_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [msim_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic [msim_pkg::OP_W-1:0]           i_opcode,
    input  wire logic [msim_pkg::SID_IN_W-1:0]       i_stack_id,
    input  wire logic signed [msim_pkg::DATA_W-1:0]  i_push_value,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic [1:0]                          i_status,
    input  wire logic signed [msim_pkg::DATA_W-1:0]  i_top_value,
    input  wire logic                                i_stack_empty,
    output int                                       o_mismatches,
    output int                                       o_pending
);

    typedef struct packed {
        msim_pkg::t_status             status;
        logic [msim_pkg::DATA_W-1:0]   top;
        logic                          empty;
    } t_stack_result;

    logic [msim_pkg::DATA_W-1:0]      stack_words [msim_pkg::DEPTH];
    logic [msim_pkg::CNT_W-1:0]       fill_level [msim_pkg::MAX_STACKS];
    logic [msim_pkg::STK_CFG_W-1:0]   stacks_reg;
    logic [msim_pkg::CAP_CFG_W-1:0]   capacity_reg;
    t_stack_result                    expected_results [$];
    int                               mismatch_count = 0;
    int                               pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic t_stack_result predict_stack_op(msim_pkg::t_opcode op,
                                                       logic [msim_pkg::SID_IN_W-1:0] sid,
                                                       logic [msim_pkg::DATA_W-1:0] val);
        t_stack_result r;
        int n_stacks;
        int cap;
        int cnt;
        int base;
        r.status = msim_pkg::ST_OK;
        r.top    = '0;
        r.empty  = 1'b0;
        n_stacks = (stacks_reg > msim_pkg::MAX_STACKS) ? msim_pkg::MAX_STACKS
                                                       : int'(stacks_reg);
        cap      = (capacity_reg > msim_pkg::MAX_CAPACITY) ? msim_pkg::MAX_CAPACITY
                                                           : int'(capacity_reg);
        if (int'(sid) >= n_stacks) begin
            r.status = msim_pkg::ST_UNDEF;
            if (op == msim_pkg::OP_PEEK) r.top = '1;
            return r;
        end
        cnt  = int'(fill_level[sid]);
        base = int'(sid) * msim_pkg::MAX_CAPACITY;
        case (op)
            msim_pkg::OP_PUSH: begin
                // a lowered capacity can leave the count above it
                if (cnt >= cap) begin
                    r.status = msim_pkg::ST_FULL;
                end else begin
                    stack_words[base + cnt] = val;
                    fill_level[sid] = msim_pkg::CNT_W'(cnt + 1);
                end
            end
            msim_pkg::OP_POP: begin
                if (cnt == 0) r.status = msim_pkg::ST_EMPTY;
                else fill_level[sid] = msim_pkg::CNT_W'(cnt - 1);
            end
            msim_pkg::OP_PEEK: begin
                if (cnt == 0) begin
                    r.status = msim_pkg::ST_EMPTY;
                    r.top    = '1;
                end else begin
                    r.top = stack_words[base + cnt - 1];
                end
            end
            default: ;
        endcase
        r.empty = (fill_level[sid] == '0);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            foreach (fill_level[k]) fill_level[k] = '0;
            stacks_reg   = msim_pkg::STK_CFG_W'(msim_pkg::MAX_STACKS);
            capacity_reg = msim_pkg::CAP_CFG_W'(msim_pkg::MAX_CAPACITY);
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (msim_pkg::t_cfg_index'(i_cfg_index))
                    msim_pkg::CFG_STACKS:
                        stacks_reg   = i_cfg_data[msim_pkg::STK_CFG_W-1:0];
                    msim_pkg::CFG_CAPACITY:
                        capacity_reg = i_cfg_data[msim_pkg::CAP_CFG_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a request taken on this edge is not matched early
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d top %0d",
                                              i_status, i_top_value));
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    if (i_top_value !== want.top)
                        report_mismatch($sformatf("top value got %0d want %0d",
                                                  i_top_value, $signed(want.top)));
                    if (i_stack_empty !== want.empty)
                        report_mismatch($sformatf("empty flag got %0b want %0b",
                                                  i_stack_empty, want.empty));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_stack_op(msim_pkg::t_opcode'(i_opcode),
                                                            i_stack_id, i_push_value));
        end
        pending_count = expected_results.size();
    end

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    msim_pkg::t_cfg_index                 cfg_index = msim_pkg::CFG_STACKS;
    logic [msim_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    msim_pkg::t_opcode                    opcode = msim_pkg::OP_PUSH;
    logic [msim_pkg::SID_IN_W-1:0]        stack_id = '0;
    logic signed [msim_pkg::DATA_W-1:0]   push_value = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [1:0]                           status;
    logic signed [msim_pkg::DATA_W-1:0]   top_value;
    logic                                 stack_empty;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cur_stacks = msim_pkg::MAX_STACKS;
    int random_items = 0;
    logic want_hold = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;

    multi_stack_in_one_memory dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_stack_id    (stack_id),
        .i_push_value  (push_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_top_value   (top_value),
        .o_stack_empty (stack_empty)
    );

    stack_op_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_stack_id    (stack_id),
        .i_push_value  (push_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_top_value   (top_value),
        .i_stack_empty (stack_empty),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off once asked for
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (want_hold && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic issue(msim_pkg::t_opcode op, int sid, logic [msim_pkg::DATA_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        stack_id   <= msim_pkg::SID_IN_W'(sid);
        push_value <= val;
        do @(posedge clk); while (in_stall);
    endtask

    // wait until every request has its result
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_config(msim_pkg::t_cfg_index idx, int value);
        logic [msim_pkg::CFG_W-1:0] d;
        settle();
        d = msim_pkg::CFG_W'($urandom);
        if (idx == msim_pkg::CFG_STACKS) begin
            // stray upper bits must be ignored by the stacks register
            d[msim_pkg::STK_CFG_W-1:0] = msim_pkg::STK_CFG_W'(value);
            cur_stacks = (value > msim_pkg::MAX_STACKS) ? msim_pkg::MAX_STACKS : value;
        end else begin
            d = msim_pkg::CFG_W'(value);
        end
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [msim_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_segment(int count, int push_pct, bit focus, int focus_sid);
        msim_pkg::t_opcode op;
        int sid;
        repeat (count) begin
            if ($urandom_range(99) < push_pct) begin
                op = msim_pkg::OP_PUSH;
            end else begin
                case ($urandom_range(2))
                    0: op = msim_pkg::OP_POP;
                    1: op = msim_pkg::OP_PEEK;
                    default: op = msim_pkg::OP_QUERY;
                endcase
            end
            if (focus) sid = focus_sid;
            else if (cur_stacks == 0 || $urandom_range(9) == 0) sid = $urandom_range(15);
            else sid = $urandom_range(cur_stacks - 1);
            issue(op, sid, pick_value());
            random_items++;
        end
    endtask

    task automatic apply_random_config();
        int stacks;
        int cap;
        case ($urandom_range(9))
            0: stacks = 0;
            1: stacks = 15;
            2: stacks = $urandom_range(9, 14);
            default: stacks = $urandom_range(1, msim_pkg::MAX_STACKS);
        endcase
        case ($urandom_range(9))
            0: cap = 0;
            1: cap = 127;
            2: cap = msim_pkg::MAX_CAPACITY;
            3: cap = $urandom_range(msim_pkg::MAX_CAPACITY + 1, 126);
            default: cap = $urandom_range(1, 6);
        endcase
        write_config(msim_pkg::CFG_STACKS, stacks);
        write_config(msim_pkg::CFG_CAPACITY, cap);
    endtask

    task automatic run_random_until(int target);
        int push_pct;
        while (random_items < target) begin
            apply_random_config();
            case ($urandom_range(3))
                0: push_pct = 30;
                1: push_pct = 50;
                2: push_pct = 70;
                default: push_pct = 90;
            endcase
            run_segment($urandom_range(20, 60), push_pct, $urandom_range(3) == 0,
                        $urandom_range(msim_pkg::MAX_STACKS - 1));
        end
    endtask

    task automatic run_directed();
        // empty stack: query, pop and peek all see nothing
        issue(msim_pkg::OP_QUERY, 0, '0);
        issue(msim_pkg::OP_POP,   0, '0);
        issue(msim_pkg::OP_PEEK,  0, '0);
        issue(msim_pkg::OP_PUSH,  0, 32'h7fff_ffff);
        issue(msim_pkg::OP_PUSH,  0, 32'h8000_0000);
        issue(msim_pkg::OP_PEEK,  0, '0);
        issue(msim_pkg::OP_POP,   0, '0);
        issue(msim_pkg::OP_PEEK,  0, '0);
        issue(msim_pkg::OP_QUERY, 0, '0);
        issue(msim_pkg::OP_PUSH,  7, '1);
        issue(msim_pkg::OP_PEEK,  7, '0);
        // stack numbers past the defined ones
        issue(msim_pkg::OP_PUSH,  8, 32'h1234_5678);
        issue(msim_pkg::OP_PEEK,  15, '0);
        issue(msim_pkg::OP_POP,   9, '0);
        issue(msim_pkg::OP_QUERY, 15, '0);
        issue(msim_pkg::OP_PUSH,  3, '0);
        issue(msim_pkg::OP_PUSH,  3, 32'd1);
        issue(msim_pkg::OP_PUSH,  3, 32'h5a5a_5a5a);
        // capacity dropped below the fill of stack 3
        write_config(msim_pkg::CFG_CAPACITY, 2);
        issue(msim_pkg::OP_PUSH,  3, 32'hdead_beef);
        issue(msim_pkg::OP_PEEK,  3, '0);
        issue(msim_pkg::OP_POP,   3, '0);
        write_config(msim_pkg::CFG_CAPACITY, 1);
        issue(msim_pkg::OP_PUSH,  1, 32'h0bad_cafe);
        issue(msim_pkg::OP_PUSH,  1, 32'h0000_0002);
        write_config(msim_pkg::CFG_CAPACITY, 0);
        issue(msim_pkg::OP_PUSH,  2, 32'h0000_0003);
        write_config(msim_pkg::CFG_CAPACITY, 127);
        issue(msim_pkg::OP_PUSH,  2, 32'hffff_fffe);
        write_config(msim_pkg::CFG_STACKS, 0);
        issue(msim_pkg::OP_QUERY, 0, '0);
        write_config(msim_pkg::CFG_STACKS, 15);
        issue(msim_pkg::OP_PEEK,  7, '0);
        issue(msim_pkg::OP_POP,   8, '0);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 60;
        run_directed();
        // fill one stack past its full capacity
        write_config(msim_pkg::CFG_STACKS, msim_pkg::MAX_STACKS);
        write_config(msim_pkg::CFG_CAPACITY, msim_pkg::MAX_CAPACITY);
        run_segment(msim_pkg::MAX_CAPACITY + 6, 100, 1'b1, 4);
        run_random_until(300);

        send_idle_pct = 60;
        recv_idle_pct = 28;
        run_random_until(560);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        want_hold = 1'b1;
        run_random_until(800);

        settle();
        repeat (8) @(negedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+src
src/msim_pkg.sv
src/msim_ctrl.sv
src/msim_dp.sv
src/multi_stack_in_one_memory.sv
bench/stack_op_checker.sv
bench/testbench.sv
